@@ rtl/core/lruvs_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU value store package
// Function codes and configuration register indexes shared by the store and
// its port checker.
// ----------------------------------------------------------------------------
package lruvs_pkg;

    typedef enum logic [1:0] {
        FUNC_STORE  = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_DECAY  = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CFG_CAPACITY  = 2'd0,
        CFG_DECAY     = 2'd1,
        CFG_THRESHOLD = 2'd2,
        CFG_UNUSED    = 2'd3
    } t_cfg_index;

    localparam logic [7:0]  CAPACITY_RST  = 8'd100;
    localparam logic [15:0] DECAY_RST     = 16'd0;
    localparam logic [14:0] THRESHOLD_RST = 15'd41;

endpackage

@@ rtl/core/lru_value_store_with_decay.sv @@
// ----------------------------------------------------------------------------
// LRU value store with decay
// Keyed value store with least-recently-used eviction and a decay tick.
// ----------------------------------------------------------------------------
// Usage:
// An input transaction (i_valid high, o_stall low) carries a function code,
// a key and a value. Each transaction produces exactly one output transaction
// (o_valid high, i_stall low) with the hit flag, the read value and the
// occupancy after the operation. Configuration writes use i_cfg_valid with
// o_cfg_ready, which is always high; they must be made by the user while the
// block is idle, which the block itself does not enforce. Entries live in
// synchronous memories with registered reads, and every operation but clear
// sweeps them one slot at a time: lookup scans them once; store scans them,
// then inserts, with a second pass when a hit or an eviction shifts the
// recency ranks; decay scales every value, then counts the dropped entries
// by rank and lowers the remaining ranks unless the store is empty.
// The block takes one item at a time; o_stall is low only while it is idle.
// A finished result waits in the output register, so the next item is taken
// while the receiver stalls; the item after that finishes only once the
// waiting result has been taken. Synchronous reset empties the store and
// loads the configuration reset values.
// ----------------------------------------------------------------------------
module lru_value_store_with_decay
    import lruvs_pkg::*;
#(
    parameter int DEPTH      = 128,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_func,
    input  logic [KEY_BITS-1:0]          i_key,
    input  logic signed [VALUE_BITS-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_found,
    output logic signed [VALUE_BITS-1:0] o_read_value,
    output logic [7:0]                   o_occupancy,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [15:0]                  i_cfg_data
);

    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CAPW = (CW > 8) ? CW : 8;
    localparam int PW   = VALUE_BITS + 17;
    localparam int TW   = (VALUE_BITS > 15) ? VALUE_BITS : 15;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_EX, S_PLAN, S_ADJ_RD, S_ADJ_EX, S_INSERT,
        S_DEC_RD, S_DEC_MUL, S_DEC_CHK, S_PFX_RD, S_PFX_EX,
        S_FIX_RD, S_FIX_AUX, S_FIX_EX, S_DONE
    } t_state;

    logic [KEY_BITS-1:0]   mem_key  [DEPTH];
    logic [VALUE_BITS-1:0] mem_val  [DEPTH];
    logic [IW-1:0]         mem_rank [DEPTH];
    logic [IW-1:0]         mem_aux  [DEPTH];

    logic [KEY_BITS-1:0]   r_key_q;
    logic [VALUE_BITS-1:0] r_val_q;
    logic [IW-1:0]         r_rank_q;
    logic [IW-1:0]         r_aux_q;

    t_state                r_state;
    logic [IW-1:0]         r_idx;
    t_func                 r_func;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic                  r_hit;
    logic [IW-1:0]         r_hit_idx;
    logic [IW-1:0]         r_hit_rank;
    logic                  r_free_ok;
    logic [IW-1:0]         r_free_idx;
    logic                  r_lru_ok;
    logic [IW-1:0]         r_lru_idx;
    logic [VALUE_BITS-1:0] r_rd_val;
    logic [IW-1:0]         r_thr;
    logic                  r_ins_ok;
    logic [IW-1:0]         r_ins_idx;
    logic [DEPTH-1:0]      r_valid;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_cum;
    logic [PW-1:0]         r_prod;
    logic                  r_pos;
    logic                  r_out_valid;
    logic                  r_found;
    logic [VALUE_BITS-1:0] r_read_value;
    logic [7:0]            r_occ;
    logic [7:0]            r_capacity;
    logic [15:0]           r_decay_rate;
    logic [14:0]           r_threshold;

    logic                  w_last;
    logic [CAPW-1:0]       w_cap_ext;
    logic [CAPW-1:0]       w_cap_eff;
    logic [16:0]           w_keep_factor;
    logic [VALUE_BITS-1:0] w_new_val;
    logic                  w_keep;
    logic                  w_key_we;
    logic                  w_val_we;
    logic [IW-1:0]         w_val_waddr;
    logic [VALUE_BITS-1:0] w_val_wdata;
    logic                  w_rank_we;
    logic [IW-1:0]         w_rank_waddr;
    logic [IW-1:0]         w_rank_wdata;
    logic                  w_aux_we;
    logic [IW-1:0]         w_aux_waddr;
    logic [IW-1:0]         w_aux_wdata;
    logic [IW-1:0]         w_aux_raddr;

    assign w_last        = (r_idx == IW'(DEPTH - 1));
    assign w_cap_ext     = CAPW'(r_capacity);
    assign w_cap_eff     = (w_cap_ext == '0) ? CAPW'(1) :
                           ((w_cap_ext > CAPW'(DEPTH)) ? CAPW'(DEPTH) : w_cap_ext);
    assign w_keep_factor = 17'h10000 - {1'b0, r_decay_rate};
    assign w_new_val     = r_pos ? r_prod[VALUE_BITS+15:16] : '0;
    assign w_keep        = (TW'(w_new_val) >= TW'(r_threshold));
    assign w_aux_raddr   = (r_state == S_FIX_AUX) ? r_rank_q : r_idx;

    always_comb begin
        w_key_we     = 1'b0;
        w_val_we     = 1'b0;
        w_val_waddr  = r_ins_idx;
        w_val_wdata  = r_val;
        w_rank_we    = 1'b0;
        w_rank_waddr = r_ins_idx;
        w_rank_wdata = IW'(r_count);
        w_aux_we     = 1'b0;
        w_aux_waddr  = r_idx;
        w_aux_wdata  = IW'(r_cum);
        unique case (r_state)
            S_INSERT: begin
                w_key_we  = r_ins_ok;
                w_val_we  = r_ins_ok;
                w_rank_we = r_ins_ok;
            end
            S_ADJ_EX: begin
                w_rank_we    = r_valid[r_idx] && (r_rank_q > r_thr);
                w_rank_waddr = r_idx;
                w_rank_wdata = r_rank_q - IW'(1);
            end
            S_DEC_CHK: begin
                w_val_we    = 1'b1;
                w_val_waddr = r_idx;
                w_val_wdata = w_new_val;
                w_aux_we    = r_valid[r_idx];
                w_aux_waddr = r_rank_q;
                w_aux_wdata = w_keep ? '0 : IW'(1);
            end
            S_PFX_EX: begin
                w_aux_we = 1'b1;
            end
            S_FIX_EX: begin
                w_rank_we    = r_valid[r_idx];
                w_rank_waddr = r_idx;
                w_rank_wdata = r_rank_q - r_aux_q;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            mem_key[r_ins_idx] <= r_key;
        end
        if (w_val_we) begin
            mem_val[w_val_waddr] <= w_val_wdata;
        end
        if (w_rank_we) begin
            mem_rank[w_rank_waddr] <= w_rank_wdata;
        end
        if (w_aux_we) begin
            mem_aux[w_aux_waddr] <= w_aux_wdata;
        end
        r_key_q  <= mem_key[r_idx];
        r_val_q  <= mem_val[r_idx];
        r_rank_q <= mem_rank[r_idx];
        r_aux_q  <= mem_aux[w_aux_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= CAPACITY_RST;
            r_decay_rate <= DECAY_RST;
            r_threshold  <= THRESHOLD_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_CAPACITY:  r_capacity   <= i_cfg_data[7:0];
                CFG_DECAY:     r_decay_rate <= i_cfg_data;
                CFG_THRESHOLD: r_threshold  <= i_cfg_data[14:0];
                CFG_UNUSED: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_func    <= t_func'(i_func);
                        r_key     <= i_key;
                        r_val     <= i_value;
                        r_hit     <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_lru_ok  <= 1'b0;
                        r_idx     <= '0;
                        unique case (t_func'(i_func))
                            FUNC_STORE, FUNC_LOOKUP: r_state <= S_SCAN_RD;
                            FUNC_DECAY:              r_state <= S_DEC_RD;
                            FUNC_CLEAR: begin
                                r_valid <= '0;
                                r_count <= '0;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN_EX;
                S_SCAN_EX: begin
                    if (r_valid[r_idx] && (r_key_q == r_key) && !r_hit) begin
                        r_hit      <= 1'b1;
                        r_hit_idx  <= r_idx;
                        r_hit_rank <= r_rank_q;
                        r_rd_val   <= r_val_q;
                    end
                    if (!r_valid[r_idx] && !r_free_ok) begin
                        r_free_ok  <= 1'b1;
                        r_free_idx <= r_idx;
                    end
                    if (r_valid[r_idx] && (r_rank_q == '0) && !r_lru_ok) begin
                        r_lru_ok  <= 1'b1;
                        r_lru_idx <= r_idx;
                    end
                    if (w_last) begin
                        r_state <= (r_func == FUNC_STORE) ? S_PLAN : S_DONE;
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_SCAN_RD;
                    end
                end
                S_PLAN: begin
                    r_idx <= '0;
                    if (r_hit) begin
                        r_valid[r_hit_idx] <= 1'b0;
                        r_count   <= r_count - CW'(1);
                        r_thr     <= r_hit_rank;
                        r_ins_ok  <= 1'b1;
                        r_ins_idx <= r_hit_idx;
                        r_state   <= S_ADJ_RD;
                    end else if ((CAPW'(r_count) >= w_cap_eff) && r_lru_ok) begin
                        r_valid[r_lru_idx] <= 1'b0;
                        r_count  <= r_count - CW'(1);
                        r_thr    <= '0;
                        r_ins_ok <= 1'b1;
                        if (!r_free_ok || (r_lru_idx < r_free_idx)) begin
                            r_ins_idx <= r_lru_idx;
                        end else begin
                            r_ins_idx <= r_free_idx;
                        end
                        r_state <= S_ADJ_RD;
                    end else begin
                        r_ins_ok  <= r_free_ok;
                        r_ins_idx <= r_free_idx;
                        r_state   <= S_INSERT;
                    end
                end
                S_ADJ_RD: r_state <= S_ADJ_EX;
                S_ADJ_EX: begin
                    if (w_last) begin
                        r_state <= S_INSERT;
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_ADJ_RD;
                    end
                end
                S_INSERT: begin
                    if (r_ins_ok) begin
                        r_valid[r_ins_idx] <= 1'b1;
                        r_count <= r_count + CW'(1);
                    end
                    r_state <= S_DONE;
                end
                S_DEC_RD: r_state <= S_DEC_MUL;
                S_DEC_MUL: begin
                    r_pos   <= ($signed(r_val_q) > 0);
                    r_prod  <= PW'(r_val_q) * PW'(w_keep_factor);
                    r_state <= S_DEC_CHK;
                end
                S_DEC_CHK: begin
                    if (r_valid[r_idx] && !w_keep) begin
                        r_valid[r_idx] <= 1'b0;
                    end
                    if (w_last) begin
                        r_idx   <= '0;
                        r_cum   <= '0;
                        r_state <= (r_count == '0) ? S_DONE : S_PFX_RD;
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_DEC_RD;
                    end
                end
                S_PFX_RD: r_state <= S_PFX_EX;
                S_PFX_EX: begin
                    r_cum <= r_cum + CW'(r_aux_q[0]);
                    if (CW'(r_idx) == (r_count - CW'(1))) begin
                        r_idx   <= '0;
                        r_state <= S_FIX_RD;
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_PFX_RD;
                    end
                end
                S_FIX_RD:  r_state <= S_FIX_AUX;
                S_FIX_AUX: r_state <= S_FIX_EX;
                S_FIX_EX: begin
                    if (w_last) begin
                        r_count <= r_count - r_cum;
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_FIX_RD;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid  <= 1'b1;
                        r_found      <= r_hit;
                        r_read_value <= (r_func == FUNC_LOOKUP && r_hit) ? r_rd_val : '0;
                        r_occ        <= 8'(r_count);
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_found      = r_found;
    assign o_read_value = r_read_value;
    assign o_occupancy  = r_occ;
    assign o_cfg_ready  = 1'b1;

endmodule

@@ rtl/core/lruvs_checker.sv @@
// ----------------------------------------------------------------------------
// LRU value store port checker
// Checks the ports of the store over time and is bound to the store module.
// ----------------------------------------------------------------------------
module lruvs_checker
    import lruvs_pkg::*;
#(
    parameter int DEPTH      = 128,
    parameter int VALUE_BITS = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic                         o_found,
    input logic signed [VALUE_BITS-1:0] o_read_value,
    input logic [7:0]                   o_occupancy
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("store accepted a second transaction without processing the first");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_found) && $stable(o_read_value)
            && $stable(o_occupancy))
        else $error("stalled output transaction changed");

    a_miss_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_read_value == '0)
        else $error("read value is nonzero without a hit");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (DEPTH < 256) |-> 32'(o_occupancy) <= 32'(DEPTH))
        else $error("occupancy exceeds the store depth");

endmodule

bind lru_value_store_with_decay lruvs_checker #(
    .DEPTH(DEPTH),
    .VALUE_BITS(VALUE_BITS)
) u_lruvs_checker (.*);
